// ===== rtl/rgb2hsl_pkg.sv =====
// rgb to hsl converter: shared package
// holds parameter defaults and the dominant-channel sector code
`timescale 1ns / 1ps

package rgb2hsl_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int HUE_BITS_DEF     = 16;
  localparam int SAT_BITS_DEF     = 16;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_RED_WRAP,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

endpackage

// ===== rtl/rgb_to_hsl_converter.sv =====
// rgb to hsl converter: top level
// uses rgb2hsl_pkg, rgb2hsl_front, rgb2hsl_div, rgb2hsl_obuf
// throughput: one pixel per clock while the output buffer has room; depth is set by the front stages plus the dividers
// s_tready drops only while the two-entry output buffer is full
// rst clears the valid bits and the output buffer; data registers are not reset
`timescale 1ns / 1ps

module rgb_to_hsl_converter #(
  parameter int CHANNEL_BITS = rgb2hsl_pkg::CHANNEL_BITS_DEF,
  parameter int HUE_BITS     = rgb2hsl_pkg::HUE_BITS_DEF,
  parameter int SAT_BITS     = rgb2hsl_pkg::SAT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // red, green, blue
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // hue, saturation, lightness_sum
  output logic [((HUE_BITS+SAT_BITS+CHANNEL_BITS+1+7)/8)*8-1:0] m_tdata,
  // achromatic
  output logic m_tuser
);

  localparam int C     = CHANNEL_BITS;
  localparam int STEPS = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;
  localparam int DEPTH = STEPS + 2;
  localparam int OUT_W = ((HUE_BITS+SAT_BITS+C+1+7)/8)*8;
  localparam int PAY_W = HUE_BITS + SAT_BITS + C + 2;

  logic             en, full;
  logic [DEPTH-1:0] valid;

  logic [C-1:0]        sat_rem, sat_div;
  logic [SAT_BITS-1:0] sat_low, sat_q;
  logic [C+2:0]        hue_rem, hue_div;
  logic [HUE_BITS-1:0] hue_q;
  logic [C:0]          sum_f;
  logic                achrom_f;

  logic [C:0]          sum_d    [STEPS+1];
  logic                achrom_d [STEPS+1];

  logic [PAY_W-1:0]    pay_in, pay_out;
  logic [HUE_BITS-1:0] hue_o;
  logic [SAT_BITS-1:0] sat_o;

  assign en       = !full;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[DEPTH-2:0], s_tvalid};
    end
  end

  rgb2hsl_front #(
    .CHANNEL_BITS(C),
    .SAT_BITS    (SAT_BITS)
  ) u_front (
    .clk       (clk),
    .en        (en),
    .red       (s_tdata[C-1:0]),
    .green     (s_tdata[2*C-1:C]),
    .blue      (s_tdata[3*C-1:2*C]),
    .sat_rem   (sat_rem),
    .sat_low   (sat_low),
    .sat_div   (sat_div),
    .hue_rem   (hue_rem),
    .hue_div   (hue_div),
    .sum       (sum_f),
    .achromatic(achrom_f)
  );

  rgb2hsl_div #(
    .DIV_BITS (C),
    .QUOT_BITS(SAT_BITS),
    .STEPS    (STEPS)
  ) u_sat_div (
    .clk   (clk),
    .en    (en),
    .rem_in(sat_rem),
    .low_in(sat_low),
    .div_in(sat_div),
    .quot  (sat_q)
  );

  rgb2hsl_div #(
    .DIV_BITS (C + 3),
    .QUOT_BITS(HUE_BITS),
    .STEPS    (STEPS)
  ) u_hue_div (
    .clk   (clk),
    .en    (en),
    .rem_in(hue_rem),
    .low_in('0),
    .div_in(hue_div),
    .quot  (hue_q)
  );

  // lightness and flag ride alongside the dividers
  assign sum_d[0]    = sum_f;
  assign achrom_d[0] = achrom_f;

  for (genvar k = 0; k < STEPS; k++) begin : g_side
    logic [C:0] sum_r;
    logic       achrom_r;
    always_ff @(posedge clk) begin
      if (en) begin
        sum_r    <= sum_d[k];
        achrom_r <= achrom_d[k];
      end
    end
    assign sum_d[k+1]    = sum_r;
    assign achrom_d[k+1] = achrom_r;
  end

  assign pay_in = {achrom_d[STEPS], sum_d[STEPS], sat_q, hue_q};

  rgb2hsl_obuf #(
    .WIDTH(PAY_W)
  ) u_obuf (
    .clk      (clk),
    .rst      (rst),
    .push     (en && valid[DEPTH-1]),
    .push_data(pay_in),
    .full     (full),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (pay_out)
  );

  assign hue_o   = pay_out[PAY_W-1] ? '0 : pay_out[HUE_BITS-1:0];
  assign sat_o   = pay_out[PAY_W-1] ? '0 : pay_out[HUE_BITS+SAT_BITS-1:HUE_BITS];
  assign m_tdata = OUT_W'({pay_out[PAY_W-2:HUE_BITS+SAT_BITS], sat_o, hue_o});
  assign m_tuser = pay_out[PAY_W-1];

endmodule

// ===== rtl/rgb2hsl_front.sv =====
// rgb to hsl converter: two front stages (max/min, sector, divider operands)
// depends on rgb2hsl_pkg
`timescale 1ns / 1ps

module rgb2hsl_front #(
  parameter int CHANNEL_BITS = rgb2hsl_pkg::CHANNEL_BITS_DEF,
  parameter int SAT_BITS     = rgb2hsl_pkg::SAT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [CHANNEL_BITS-1:0]   red,
  input  logic [CHANNEL_BITS-1:0]   green,
  input  logic [CHANNEL_BITS-1:0]   blue,
  output logic [CHANNEL_BITS-1:0]   sat_rem,
  output logic [SAT_BITS-1:0]       sat_low,
  output logic [CHANNEL_BITS-1:0]   sat_div,
  output logic [CHANNEL_BITS+2:0]   hue_rem,
  output logic [CHANNEL_BITS+2:0]   hue_div,
  output logic [CHANNEL_BITS:0]     sum,
  output logic                      achromatic
);

  localparam int C = CHANNEL_BITS;

  logic                red_max, green_max, red_min, green_min;
  logic [C-1:0]        hi, lo;
  rgb2hsl_pkg::sector_t sec_next;
  logic signed [C:0]   diff_next;

  logic [C-1:0]        spread_a;
  logic [C:0]          sum_a;
  rgb2hsl_pkg::sector_t sec_a;
  logic signed [C:0]   diff_a;
  logic                achrom_a;

  logic [C+2:0]        s2, s4, s6, base;
  logic signed [C+3:0] numer;
  logic [C:0]          denom_wide;
  logic [C+SAT_BITS-1:0] sat_num;

  // stage a: ordering of the channels
  always_comb begin
    red_max   = (red >= green) && (red >= blue);
    green_max = !red_max && (green >= blue);
    red_min   = (red <= green) && (red <= blue);
    green_min = !red_min && (green <= blue);
    hi = red_max ? red : (green_max ? green : blue);
    lo = red_min ? red : (green_min ? green : blue);
    if (red_max) begin
      diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
      sec_next  = (green < blue) ? rgb2hsl_pkg::SEC_RED_WRAP : rgb2hsl_pkg::SEC_RED;
    end else if (green_max) begin
      diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
      sec_next  = rgb2hsl_pkg::SEC_GREEN;
    end else begin
      diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
      sec_next  = rgb2hsl_pkg::SEC_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spread_a <= hi - lo;
      sum_a    <= {1'b0, hi} + {1'b0, lo};
      sec_a    <= sec_next;
      diff_a   <= diff_next;
      achrom_a <= (hi == lo);
    end
  end

  // stage b: divider operands
  always_comb begin
    s2 = {2'b00, spread_a, 1'b0};
    s4 = {1'b0, spread_a, 2'b00};
    s6 = s2 + s4;
    unique case (sec_a)
      rgb2hsl_pkg::SEC_RED:      base = '0;
      rgb2hsl_pkg::SEC_RED_WRAP: base = s6;
      rgb2hsl_pkg::SEC_GREEN:    base = s2;
      rgb2hsl_pkg::SEC_BLUE:     base = s4;
      default:                   base = '0;
    endcase
    numer = $signed({1'b0, base}) + $signed({{3{diff_a[C]}}, diff_a});
    // above half scale the denominator folds back
    denom_wide = sum_a[C] ? ({{C{1'b1}}, 1'b0} - sum_a) : sum_a;
    sat_num = {spread_a, {SAT_BITS{1'b0}}} - {{SAT_BITS{1'b0}}, spread_a};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_rem    <= sat_num[C+SAT_BITS-1:SAT_BITS];
      sat_low    <= sat_num[SAT_BITS-1:0];
      sat_div    <= denom_wide[C-1:0];
      hue_rem    <= numer[C+2:0];
      hue_div    <= s6;
      sum        <= sum_a;
      achromatic <= achrom_a;
    end
  end

endmodule

// ===== rtl/rgb2hsl_div.sv =====
// rgb to hsl: pipelined restoring divider, one quotient bit per work stage
// depends on rgb2hsl_pkg; shares the pipeline enable of the top level
`timescale 1ns / 1ps

module rgb2hsl_div #(
  parameter int DIV_BITS  = rgb2hsl_pkg::CHANNEL_BITS_DEF,
  parameter int QUOT_BITS = rgb2hsl_pkg::SAT_BITS_DEF,
  parameter int STEPS     = rgb2hsl_pkg::SAT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_BITS-1:0]  rem_in,
  input  logic [QUOT_BITS-1:0] low_in,
  input  logic [DIV_BITS-1:0]  div_in,
  output logic [QUOT_BITS-1:0] quot
);

  logic [DIV_BITS-1:0]  rem [STEPS+1];
  logic [QUOT_BITS-1:0] low [STEPS+1];
  logic [DIV_BITS-1:0]  dv  [STEPS+1];
  logic [QUOT_BITS-1:0] qt  [STEPS+1];

  assign rem[0] = rem_in;
  assign low[0] = low_in;
  assign dv[0]  = div_in;
  assign qt[0]  = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int BIT = STEPS - 1 - k;
    logic [DIV_BITS-1:0]  rem_r;
    logic [QUOT_BITS-1:0] low_r;
    logic [DIV_BITS-1:0]  dv_r;
    logic [QUOT_BITS-1:0] qt_r;

    if (BIT < QUOT_BITS) begin : g_work
      logic [DIV_BITS:0] trial;
      logic              ge;
      assign trial = {rem[k], low[k][BIT]};
      assign ge    = trial >= {1'b0, dv[k]};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r <= ge ? DIV_BITS'(trial - {1'b0, dv[k]}) : trial[DIV_BITS-1:0];
          qt_r  <= {qt[k][QUOT_BITS-2:0], ge};
          low_r <= low[k];
          dv_r  <= dv[k];
        end
      end
    end else begin : g_wait
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r <= rem[k];
          qt_r  <= qt[k];
          low_r <= low[k];
          dv_r  <= dv[k];
        end
      end
    end

    assign rem[k+1] = rem_r;
    assign low[k+1] = low_r;
    assign dv[k+1]  = dv_r;
    assign qt[k+1]  = qt_r;
  end

  assign quot = qt[STEPS];

endmodule

// ===== rtl/rgb2hsl_obuf.sv =====
// rgb to hsl converter: two-entry output buffer between pipeline and output port
// stand-alone
`timescale 1ns / 1ps

module rgb2hsl_obuf #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wptr, rptr;
  logic [1:0]       count, count_next;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = count[1];
  assign out_data  = entry[rptr];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      count <= count_next;
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wptr] <= push_data;
  end

endmodule

// ===== rtl/rgb2hsl_checker.sv =====
// rgb to hsl converter: port checker and its bind to the top level
// depends on rgb2hsl_pkg for parameter defaults
`timescale 1ns / 1ps

module rgb2hsl_checker #(
  parameter int CHANNEL_BITS = rgb2hsl_pkg::CHANNEL_BITS_DEF,
  parameter int HUE_BITS     = rgb2hsl_pkg::HUE_BITS_DEF,
  parameter int SAT_BITS     = rgb2hsl_pkg::SAT_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((HUE_BITS+SAT_BITS+CHANNEL_BITS+1+7)/8)*8-1:0] m_tdata,
  input logic m_tuser
);

  localparam int HS = HUE_BITS + SAT_BITS;

  logic [CHANNEL_BITS:0] sum_out;
  assign sum_out = m_tdata[HS+CHANNEL_BITS:HS];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // gray pixels carry zero hue and saturation
  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[HS-1:0] == '0)
    else $error("achromatic result with nonzero hue or saturation");

  // a colored pixel is neither black nor white
  a_color_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> sum_out != '0 && sum_out != {{CHANNEL_BITS{1'b1}}, 1'b0})
    else $error("chromatic result with extreme lightness");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("results present after reset");

endmodule

bind rgb_to_hsl_converter rgb2hsl_checker #(
  .CHANNEL_BITS(CHANNEL_BITS),
  .HUE_BITS    (HUE_BITS),
  .SAT_BITS    (SAT_BITS)
) u_checker (.*);

// ===== tb/hsl_checker.sv =====
// rgb to hsl converter: scoreboard watching both stream channels
// predicts hue, saturation and lightness for every accepted pixel and compares
// depends on rgb2hsl_pkg for parameter defaults and the sector encoding
`timescale 1ns / 1ps

module hsl_checker #(
  parameter int CB = rgb2hsl_pkg::CHANNEL_BITS_DEF,
  parameter int HB = rgb2hsl_pkg::HUE_BITS_DEF,
  parameter int SB = rgb2hsl_pkg::SAT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  // red, green, blue
  input  logic [((3*CB+7)/8)*8-1:0] s_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  // hue, saturation, lightness_sum
  input  logic [((HB+SB+CB+1+7)/8)*8-1:0] m_tdata,
  // achromatic
  input  logic m_tuser,
  output int unsigned failures,
  output int unsigned pending
);

  localparam longint unsigned CMAX     = (64'd1 << CB) - 1;
  localparam longint unsigned SAT_FULL = (64'd1 << SB) - 1;

  typedef struct packed {
    logic [HB-1:0] hue;
    logic [SB-1:0] saturation;
    logic [CB:0]   lightness_sum;
    logic          achromatic;
  } hsl_t;

  hsl_t hsl_pending_q[$];

  function automatic hsl_t hsl_of_pixel(input logic [CB-1:0] red, green, blue);
    hsl_t res;
    longint unsigned r, g, b;
    longint unsigned hi, lo, sum, spread, denom, numer;
    rgb2hsl_pkg::sector_t dom;
    r = 64'(red);
    g = 64'(green);
    b = 64'(blue);
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    sum = hi + lo;
    res.lightness_sum = sum[CB:0];
    if (hi == lo) begin
      res.hue = '0;
      res.saturation = '0;
      res.achromatic = 1'b1;
      return res;
    end
    spread = hi - lo;
    denom = (sum <= CMAX) ? sum : 2 * CMAX - sum;
    res.saturation = SB'((spread * SAT_FULL) / denom);
    res.achromatic = 1'b0;
    if (hi == r) dom = (g < b) ? rgb2hsl_pkg::SEC_RED_WRAP : rgb2hsl_pkg::SEC_RED;
    else if (hi == g) dom = rgb2hsl_pkg::SEC_GREEN;
    else dom = rgb2hsl_pkg::SEC_BLUE;
    case (dom)
      rgb2hsl_pkg::SEC_RED:      numer = g - b;
      rgb2hsl_pkg::SEC_RED_WRAP: numer = 6 * spread + g - b;
      rgb2hsl_pkg::SEC_GREEN:    numer = 2 * spread + b - r;
      default:                   numer = 4 * spread + r - g;
    endcase
    res.hue = HB'((numer << HB) / (6 * spread));
    return res;
  endfunction

  always @(posedge clk) begin
    hsl_t want;
    if (rst) begin
      failures = 0;
      pending = 0;
      hsl_pending_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        hsl_pending_q.push_back(hsl_of_pixel(s_tdata[CB-1:0], s_tdata[2*CB-1:CB],
                                             s_tdata[3*CB-1:2*CB]));
      if (m_tvalid && m_tready) begin
        if (hsl_pending_q.size() == 0) begin
          $error("result with no request outstanding: tdata %h tuser %b", m_tdata, m_tuser);
          failures = failures + 1;
        end else begin
          want = hsl_pending_q.pop_front();
          if (m_tdata[HB-1:0] !== want.hue) begin
            $error("hue expected %0d got %0d", want.hue, m_tdata[HB-1:0]);
            failures = failures + 1;
          end
          if (m_tdata[HB+SB-1:HB] !== want.saturation) begin
            $error("saturation expected %0d got %0d", want.saturation, m_tdata[HB+SB-1:HB]);
            failures = failures + 1;
          end
          if (m_tdata[HB+SB+CB:HB+SB] !== want.lightness_sum) begin
            $error("lightness_sum expected %0d got %0d", want.lightness_sum,
                   m_tdata[HB+SB+CB:HB+SB]);
            failures = failures + 1;
          end
          if (m_tuser !== want.achromatic) begin
            $error("achromatic expected %0d got %0d", want.achromatic, m_tuser);
            failures = failures + 1;
          end
        end
      end
      pending = hsl_pending_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// rgb to hsl converter: top of the testbench
// drives pixel requests and result backpressure, gives the verdict
// depends on rgb2hsl_pkg, rgb_to_hsl_converter and hsl_checker
`timescale 1ns / 1ps

module testbench;

  localparam int CB = rgb2hsl_pkg::CHANNEL_BITS_DEF;
  localparam int HB = rgb2hsl_pkg::HUE_BITS_DEF;
  localparam int SB = rgb2hsl_pkg::SAT_BITS_DEF;
  localparam int RANDOM_PIXELS = 1600;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [((3*CB+7)/8)*8-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [((HB+SB+CB+1+7)/8)*8-1:0] m_tdata;
  logic m_tuser;

  int unsigned failures;
  int unsigned pending;

  bit tx_slow = 1'b1;
  bit rx_slow = 1'b1;
  int unsigned holds_asked = 0;

  always #10 clk = ~clk;

  rgb_to_hsl_converter #(
    .CHANNEL_BITS(CB),
    .HUE_BITS(HB),
    .SAT_BITS(SB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  hsl_checker #(
    .CB(CB),
    .HB(HB),
    .SB(SB)
  ) scoreboard (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .failures(failures),
    .pending(pending)
  );

  task automatic send_pixel(input logic [CB-1:0] red, green, blue);
    int unsigned gap;
    gap = tx_slow ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {blue, green, red};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  initial begin
    #5000000;
    $display("[rgb_to_hsl_converter] ERROR");
    $finish;
  end

  // result side backpressure
  initial begin
    int unsigned stall;
    int unsigned holds_done;
    holds_done = 0;
    @(negedge clk iff !rst);
    forever begin
      if (holds_asked != holds_done) begin
        stall = HOLD_CYCLES;
        holds_done = holds_asked;
      end else begin
        stall = rx_slow ? $urandom_range(0, 6) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    logic [CB-1:0] red, green, blue;
    logic [CB-1:0] extremes [4];
    extremes = '{8'd0, 8'd1, 8'd254, 8'd255};
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // gray levels, primaries, ties between channels, sum boundary cases
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd200, 8'd10, 8'd199);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd127, 8'd128, 8'd128);
    send_pixel(8'd128, 8'd127, 8'd127);
    send_pixel(8'd128, 8'd128, 8'd127);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd50, 8'd100, 8'd200);
    send_pixel(8'd100, 8'd200, 8'd50);
    send_pixel(8'd170, 8'd85, 8'd255);
    send_pixel(8'd0, 8'd1, 8'd1);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 150 == 0) begin
        tx_slow = ($urandom_range(0, 3) != 0);
        rx_slow = ($urandom_range(0, 3) != 0);
      end
      if (i == 400 || i == 1200) holds_asked = holds_asked + 1;
      if (i == 800) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(negedge clk);
      end
      red = CB'($urandom);
      green = CB'($urandom);
      blue = CB'($urandom);
      case ($urandom_range(0, 9))
        0, 1: begin
          green = red;
          blue = red;
        end
        2: green = red;
        3: blue = green;
        4: blue = red;
        5, 6: begin
          red = extremes[2'($urandom_range(0, 3))];
          green = extremes[2'($urandom_range(0, 3))];
          blue = extremes[2'($urandom_range(0, 3))];
        end
        default: ;
      endcase
      send_pixel(red, green, blue);
    end
    s_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (40) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("[rgb_to_hsl_converter] OK");
    end else begin
      $display("[rgb_to_hsl_converter] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rgb2hsl_pkg.sv
rtl/rgb2hsl_front.sv
rtl/rgb2hsl_div.sv
rtl/rgb2hsl_obuf.sv
rtl/rgb_to_hsl_converter.sv
rtl/rgb2hsl_checker.sv
tb/hsl_checker.sv
tb/testbench.sv
